### rtl/tsr_pkg.sv
// Shared types and constants for the three sonar ranging scanner.
// Item structs, configuration register map, reset values and scaling constants.
// No dependencies; compiled first.
package tsr_pkg;

	localparam int SENSORS_DEF  = 3;
	localparam int MEDIAN_DEPTH = 3;
	localparam int SIDES        = 3;

	localparam int ECHO_IN_W = 16;
	localparam int ECHO_W    = 12;
	localparam int DIST_W    = 7;
	localparam int LIMIT_W   = 7;
	localparam int PERIOD_W  = 8;
	localparam int HOLD_W    = 16;
	localparam int SEL_W     = 2;
	localparam int PTR_W     = $clog2(MEDIAN_DEPTH);
	localparam int FILL_W    = $clog2(MEDIAN_DEPTH + 1);

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// distance = floor(median * 1000 / 58773), done as multiply and shift
	localparam longint unsigned CM_NUM   = 64'd1000;
	localparam longint unsigned CM_DEN   = 64'd58773;
	localparam int              CM_SHIFT = 28;
	localparam longint unsigned CM_MULT  = ((CM_NUM << CM_SHIFT) + CM_DEN - 1) / CM_DEN;
	localparam int              CM_MULT_W = 23;

	localparam logic [PERIOD_W-1:0] MS_RESET = 8'd50;

	localparam logic                RST_ENABLE = 1'b1;
	localparam logic [LIMIT_W-1:0]  RST_LIMIT  = 7'd25;
	localparam logic [LIMIT_W-1:0]  RST_MARGIN = 7'd10;
	localparam logic [PERIOD_W-1:0] RST_PERIOD = 8'd50;
	localparam logic [HOLD_W-1:0]   RST_HOLD   = 16'd5000;
	localparam logic [ECHO_W-1:0]   RST_MAX    = 12'd4000;

	typedef enum logic {
		OP_ECHO = 1'b0,
		OP_TICK = 1'b1
	} op_e;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLE       = 3'd0,
		REG_LEFT_LIMIT   = 3'd1,
		REG_CENTER_LIMIT = 3'd2,
		REG_RIGHT_LIMIT  = 3'd3,
		REG_SLOW_MARGIN  = 3'd4,
		REG_PING_PERIOD  = 3'd5,
		REG_NEAR_HOLD    = 3'd6,
		REG_MAX_ECHO     = 3'd7
	} cfg_reg_e;

	typedef struct packed {
		op_e                  operation;
		logic [ECHO_IN_W-1:0] echo_us;
		logic [SEL_W-1:0]     echo_sensor;
	} in_item_t;

	typedef struct packed {
		logic [DIST_W-1:0] dist_left_cm;
		logic [DIST_W-1:0] dist_center_cm;
		logic [DIST_W-1:0] dist_right_cm;
		logic              obstacle_flag;
		logic              near_flag;
		logic              trigger_pulse;
		logic [SEL_W-1:0]  trigger_sensor;
	} out_item_t;

	typedef struct packed {
		logic                scan_enable;
		logic [LIMIT_W-1:0]  left_limit_cm;
		logic [LIMIT_W-1:0]  center_limit_cm;
		logic [LIMIT_W-1:0]  right_limit_cm;
		logic [LIMIT_W-1:0]  slow_margin_cm;
		logic [PERIOD_W-1:0] ping_period_ms;
		logic [HOLD_W-1:0]   near_hold_ms;
		logic [ECHO_W-1:0]   max_echo_us;
	} cfg_t;

endpackage

### rtl/tsr_if.sv
// Handshake channels of the scanner: echo/tick input, report output, config writes.
// Depends on tsr_pkg for the item types.
interface tsr_echo_if;
	import tsr_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tsr_report_if;
	import tsr_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface tsr_cfg_if;
	import tsr_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/three_sonar_ranging_scanner.sv
// Three sonar ranging scanner: round-robin ping control, median filtering, obstacle flags.
// An accepted item is held in the input register; its report goes to the result register.
// Throughput: one item per cycle unless a stalled sink holds a full report register.
// The update for an item (window, median, scaling, flags) is computed combinationally.
// Reset: asynchronous, active low; resets control state, config to defaults, distances to 0.
// Depends on tsr_pkg, tsr_if, tsr_cfg_regs and tsr_sonar_filter.
module three_sonar_ranging_scanner #(
	parameter int SENSORS = tsr_pkg::SENSORS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	tsr_echo_if.sink      echo,
	tsr_report_if.source  report,
	tsr_cfg_if.sink       cfg
);
	import tsr_pkg::*;

	localparam int SW = $clog2(SENSORS);
	localparam int CW = (SW > SEL_W) ? SW : SEL_W;

	cfg_t      regs;
	logic      v_s1;
	in_item_t  item_s1;
	logic      advance;
	logic      out_valid_q;
	out_item_t out_q;
	out_item_t res;

	logic [SW-1:0]       act_q, act_n;
	logic                seen_q, seen_n;
	logic [PERIOD_W-1:0] ms_q, ms_n;
	logic [HOLD_W-1:0]   hold_q, hold_n, hold_dec;
	logic [PERIOD_W:0]   elapsed;
	logic                push, clear, trig, obst, near;
	logic [ECHO_W-1:0]   push_val;
	logic [CW-1:0]       act_ext, who_ext, trig_ext;

	logic [DIST_W-1:0]  dist_nxt [SENSORS];
	logic [DIST_W-1:0]  side_d   [SIDES];
	logic [LIMIT_W-1:0] lims     [SIDES];
	logic [SIDES-1:0]   below, near_below;

	tsr_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	assign advance    = v_s1 && (!out_valid_q || report.ready);
	assign echo.ready = !v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (echo.ready) begin
			v_s1 <= echo.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (echo.ready && echo.valid) begin
			item_s1 <= echo.data;
		end
	end

	always_comb begin
		act_ext  = CW'(act_q);
		who_ext  = CW'(item_s1.echo_sensor);
		elapsed  = {1'b0, ms_q} + 1'b1;
		hold_dec = ((item_s1.operation == OP_TICK) && (hold_q != '0)) ? hold_q - 1'b1 : hold_q;
		act_n    = act_q;
		seen_n   = seen_q;
		ms_n     = ms_q;
		push     = 1'b0;
		clear    = 1'b0;
		push_val = regs.max_echo_us;
		trig     = 1'b0;
		if (!regs.scan_enable) begin
			clear = advance;
			if ((item_s1.operation == OP_TICK) && (ms_q != '1)) begin
				ms_n = ms_q + 1'b1;
			end
		end else if (item_s1.operation == OP_ECHO) begin
			if ((item_s1.echo_us != '0) && (who_ext == act_ext)) begin
				seen_n = 1'b1;
				push   = advance;
				if (item_s1.echo_us <= ECHO_IN_W'(regs.max_echo_us)) begin
					push_val = item_s1.echo_us[ECHO_W-1:0];
				end
			end
		end else if (elapsed > {1'b0, regs.ping_period_ms}) begin
			push   = advance && !seen_q;
			seen_n = 1'b0;
			act_n  = (act_q == SW'(SENSORS - 1)) ? '0 : act_q + 1'b1;
			trig   = 1'b1;
			ms_n   = '0;
		end else begin
			ms_n = elapsed[PERIOD_W-1:0];
		end
	end

	tsr_sonar_filter #(.SENSORS(SENSORS)) u_filter (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.clear       (clear),
		.push_sensor (act_q),
		.push_value  (push_val),
		.dist_nxt    (dist_nxt)
	);

	assign lims[0] = regs.left_limit_cm;
	assign lims[1] = regs.center_limit_cm;
	assign lims[2] = regs.right_limit_cm;

	for (genvar k = 0; k < SIDES; k++) begin : g_side
		if (k < SENSORS) begin : g_used
			assign side_d[k]     = dist_nxt[k];
			assign below[k]      = side_d[k] < lims[k];
			assign near_below[k] = {1'b0, side_d[k]} <
				({1'b0, lims[k]} + {1'b0, regs.slow_margin_cm});
		end else begin : g_absent
			assign side_d[k]     = '0;
			assign below[k]      = 1'b0;
			assign near_below[k] = 1'b0;
		end
	end

	always_comb begin
		obst   = regs.scan_enable && (|below);
		near   = 1'b0;
		hold_n = hold_dec;
		if (regs.scan_enable) begin
			if (hold_dec != '0) begin
				near = 1'b1;
			end else if (|near_below) begin
				near   = 1'b1;
				hold_n = regs.near_hold_ms;
			end
		end
		trig_ext           = CW'(act_n);
		res.dist_left_cm   = side_d[0];
		res.dist_center_cm = side_d[1];
		res.dist_right_cm  = side_d[2];
		res.obstacle_flag  = obst;
		res.near_flag      = near;
		res.trigger_pulse  = trig;
		res.trigger_sensor = trig_ext[SEL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q       <= '0;
			seen_q      <= 1'b0;
			ms_q        <= MS_RESET;
			hold_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				act_q       <= act_n;
				seen_q      <= seen_n;
				ms_q        <= ms_n;
				hold_q      <= hold_n;
				out_valid_q <= 1'b1;
			end else if (report.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	assign report.valid = out_valid_q;
	assign report.data  = out_q;

endmodule

### rtl/tsr_cfg_regs.sv
// Configuration register file of the scanner.
// Depends on tsr_pkg and tsr_cfg_if.
module tsr_cfg_regs (
	input  logic         clk,
	input  logic         arst_n,
	tsr_cfg_if.sink      cfg,
	output tsr_pkg::cfg_t regs
);
	import tsr_pkg::*;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs.scan_enable     <= RST_ENABLE;
			regs.left_limit_cm   <= RST_LIMIT;
			regs.center_limit_cm <= RST_LIMIT;
			regs.right_limit_cm  <= RST_LIMIT;
			regs.slow_margin_cm  <= RST_MARGIN;
			regs.ping_period_ms  <= RST_PERIOD;
			regs.near_hold_ms    <= RST_HOLD;
			regs.max_echo_us     <= RST_MAX;
		end else if (cfg.valid) begin
			unique case (cfg_reg_e'(cfg.index))
				REG_ENABLE:       regs.scan_enable     <= cfg.data[0];
				REG_LEFT_LIMIT:   regs.left_limit_cm   <= cfg.data[LIMIT_W-1:0];
				REG_CENTER_LIMIT: regs.center_limit_cm <= cfg.data[LIMIT_W-1:0];
				REG_RIGHT_LIMIT:  regs.right_limit_cm  <= cfg.data[LIMIT_W-1:0];
				REG_SLOW_MARGIN:  regs.slow_margin_cm  <= cfg.data[LIMIT_W-1:0];
				REG_PING_PERIOD:  regs.ping_period_ms  <= cfg.data[PERIOD_W-1:0];
				REG_NEAR_HOLD:    regs.near_hold_ms    <= cfg.data[HOLD_W-1:0];
				REG_MAX_ECHO:     regs.max_echo_us     <= cfg.data[ECHO_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

### rtl/tsr_sonar_filter.sv
// Per-sensor median-of-three windows and centimetre conversion.
// Presents next-state distances combinationally; depends on tsr_pkg.
module tsr_sonar_filter #(
	parameter int SENSORS = tsr_pkg::SENSORS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic                         clear,
	input  logic [$clog2(SENSORS)-1:0]   push_sensor,
	input  logic [tsr_pkg::ECHO_W-1:0]   push_value,
	output logic [tsr_pkg::DIST_W-1:0]   dist_nxt [SENSORS]
);
	import tsr_pkg::*;

	localparam int SW = $clog2(SENSORS);
	localparam int PW = ECHO_W + CM_MULT_W;

	logic [ECHO_W-1:0] win_q  [SENSORS][MEDIAN_DEPTH];
	logic [FILL_W-1:0] fill_q [SENSORS];
	logic [PTR_W-1:0]  ptr_q  [SENSORS];
	logic [DIST_W-1:0] dist_q [SENSORS];

	logic [ECHO_W-1:0] row [MEDIAN_DEPTH];
	logic [PTR_W-1:0]  ptr_cur;
	logic [PTR_W-1:0]  ptr_new;
	logic [FILL_W-1:0] fill_cur;
	logic [FILL_W-1:0] fill_new;
	logic [ECHO_W-1:0] lo01;
	logic [ECHO_W-1:0] hi01;
	logic [ECHO_W-1:0] hi_c;
	logic [ECHO_W-1:0] med;
	logic [PW-1:0]     prod;
	logic [DIST_W-1:0] dist_new;

	always_comb begin
		ptr_cur  = ptr_q[push_sensor];
		fill_cur = fill_q[push_sensor];
		for (int i = 0; i < MEDIAN_DEPTH; i++) begin
			row[i] = (PTR_W'(i) == ptr_cur) ? push_value : win_q[push_sensor][i];
		end
		fill_new = (fill_cur == FILL_W'(MEDIAN_DEPTH)) ? fill_cur : fill_cur + 1'b1;
		ptr_new  = (ptr_cur == PTR_W'(MEDIAN_DEPTH - 1)) ? '0 : ptr_cur + 1'b1;

		lo01 = (row[0] < row[1]) ? row[0] : row[1];
		hi01 = (row[0] < row[1]) ? row[1] : row[0];
		hi_c = (hi01 < row[2]) ? hi01 : row[2];
		if (fill_new == FILL_W'(1)) begin
			med = row[0];
		end else if (fill_new == FILL_W'(2)) begin
			med = hi01;
		end else begin
			med = (lo01 > hi_c) ? lo01 : hi_c;
		end

		prod     = PW'(med) * PW'(CM_MULT_W'(CM_MULT));
		dist_new = prod[CM_SHIFT +: DIST_W];

		for (int s = 0; s < SENSORS; s++) begin
			if (clear) begin
				dist_nxt[s] = '0;
			end else if (push && (SW'(s) == push_sensor)) begin
				dist_nxt[s] = dist_new;
			end else begin
				dist_nxt[s] = dist_q[s];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			win_q[push_sensor][ptr_cur] <= push_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SENSORS; s++) begin
				fill_q[s] <= '0;
				ptr_q[s]  <= '0;
				dist_q[s] <= '0;
			end
		end else begin
			if (push) begin
				fill_q[push_sensor] <= fill_new;
				ptr_q[push_sensor]  <= ptr_new;
			end
			if (push || clear) begin
				for (int s = 0; s < SENSORS; s++) begin
					dist_q[s] <= dist_nxt[s];
				end
			end
		end
	end

endmodule

### rtl/tsr_checker.sv
// Port-level assertions for the scanner, attached to the top level by bind.
// Depends on tsr_pkg and three_sonar_ranging_scanner.
module tsr_checker #(
	parameter int SENSORS = tsr_pkg::SENSORS_DEF
) (
	input logic                clk,
	input logic                arst_n,
	input logic                echo_ready,
	input logic                report_valid,
	input logic                report_ready,
	input tsr_pkg::out_item_t  report_data
);
	import tsr_pkg::*;

	a_report_hold: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid && !report_ready |=> report_valid)
		else $error("report valid dropped while stalled");

	a_report_stable: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid && !report_ready |=> $stable(report_data))
		else $error("report item changed while stalled");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!report_valid |-> echo_ready)
		else $error("input stalled with empty report register");

	a_obst_implies_near: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid && report_data.obstacle_flag |-> report_data.near_flag)
		else $error("obstacle flag without near flag");

	a_sensor_range: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid && (SENSORS < 4) |-> (report_data.trigger_sensor < SENSORS))
		else $error("trigger sensor out of range");

endmodule

bind three_sonar_ranging_scanner tsr_checker #(.SENSORS(SENSORS)) u_tsr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.echo_ready   (echo.ready),
	.report_valid (report.valid),
	.report_ready (report.ready),
	.report_data  (report.data)
);
